@@ design/assert_macros.svh @@
// Assertion macros shared by the nearest-node search RTL.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define NNHS_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("nnhs assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define NNHS_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nnhs assertion failed");

// Consequent holds in the cycle after the antecedent.
`define NNHS_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nnhs assertion failed");

`endif

@@ design/nnhs_pkg.sv @@
// Package of the nearest-node search: widths, codes, command and status
// structs, and the CORDIC arctangent table. No dependencies.
package nnhs_pkg;

	localparam int unsigned MaxNodesDef    = 1024;
	localparam int unsigned CordicStepsDef = 24;

	localparam int unsigned LatW    = 31;
	localparam int unsigned LonW    = 32;
	localparam int unsigned CoordW  = 32;
	localparam int unsigned IdxOutW = 10;
	localparam int unsigned StatW   = 2;
	localparam int unsigned AngW    = 33;
	localparam int unsigned TrigW   = 33;
	localparam int unsigned AW      = 32;
	localparam int unsigned StepW   = 6;

	localparam logic [29:0]           TurnScale  = 30'd640511947;
	localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [StatW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_CMP,
		S_ADD_END,
		S_Q_START,
		S_Q_WAIT,
		S_Q_HAV,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic load_item;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic append;
		logic cordic_start;
		logic hav_start;
		logic best_upd;
		logic res_found;
		logic res_new;
		logic res_full;
		logic res_empty;
		logic res_best;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic idx_last;
		logic match;
		logic cordic_done;
		logic a_valid;
	} sts_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic signed [AngW-1:0] atan_turn(input logic [4:0] i);
		logic signed [AngW-1:0] v;
		case (i)
			5'd0:  v = 33'sd536870912;
			5'd1:  v = 33'sd316933406;
			5'd2:  v = 33'sd167458907;
			5'd3:  v = 33'sd85004756;
			5'd4:  v = 33'sd42667331;
			5'd5:  v = 33'sd21354465;
			5'd6:  v = 33'sd10679838;
			5'd7:  v = 33'sd5340245;
			5'd8:  v = 33'sd2670163;
			5'd9:  v = 33'sd1335087;
			5'd10: v = 33'sd667544;
			5'd11: v = 33'sd333772;
			5'd12: v = 33'sd166886;
			5'd13: v = 33'sd83443;
			5'd14: v = 33'sd41722;
			5'd15: v = 33'sd20861;
			5'd16: v = 33'sd10430;
			5'd17: v = 33'sd5215;
			5'd18: v = 33'sd2608;
			5'd19: v = 33'sd1304;
			5'd20: v = 33'sd652;
			5'd21: v = 33'sd326;
			5'd22: v = 33'sd163;
			5'd23: v = 33'sd81;
			5'd24: v = 33'sd41;
			5'd25: v = 33'sd20;
			5'd26: v = 33'sd10;
			5'd27: v = 33'sd5;
			5'd28: v = 33'sd3;
			5'd29: v = 33'sd1;
			5'd30: v = 33'sd1;
			default: v = 33'sd0;
		endcase
		return v;
	endfunction

endpackage

@@ design/nnhs_item_if.sv @@
// Input channel of the nearest-node search: valid/ready plus item fields.
// Depends on nnhs_pkg.
interface nnhs_item_if import nnhs_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic                   func;
	logic signed [LatW-1:0] lat;
	logic signed [LonW-1:0] lon;

	modport source (output valid, func, lat, lon, input ready);
	modport sink (input valid, func, lat, lon, output ready);
endinterface

@@ design/nnhs_result_if.sv @@
// Output channel of the nearest-node search: valid/ready plus result fields.
// Depends on nnhs_pkg.
interface nnhs_result_if import nnhs_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [IdxOutW-1:0] node_index;
	logic [StatW-1:0]   status;
	logic               was_new;

	modport source (output valid, node_index, status, was_new, input ready);
	modport sink (input valid, node_index, status, was_new, output ready);
endinterface

@@ design/nnhs_cordic.sv @@
// Iterative CORDIC sine/cosine with angle conversion from 5e-8 degree units.
// Depends on nnhs_pkg.
module nnhs_cordic import nnhs_pkg::*; #(
	parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [AngW-1:0]  angle,
	output logic                    done,
	output logic signed [TrigW-1:0] cos_val,
	output logic signed [TrigW-1:0] sin_val
);

	logic [AngW-1:0]         mag;
	logic [46:0]             prod_hi_q;
	logic [45:0]             prod_lo_q;
	logic                    neg_q;
	logic [63:0]             sum;
	logic [31:0]             t_mag;
	logic [31:0]             t;
	logic [31:0]             tq;
	logic [1:0]              quad;
	logic [31:0]             resid;
	logic                    conv_q;
	logic                    run_q;
	logic                    done_q;
	logic [StepW-1:0]        step_q;
	logic [1:0]              quad_q;
	logic signed [TrigW-1:0] x_q;
	logic signed [TrigW-1:0] y_q;
	logic signed [AngW-1:0]  z_q;
	logic signed [TrigW-1:0] dx;
	logic signed [TrigW-1:0] dy;
	logic signed [AngW-1:0]  at;

	assign mag   = angle[AngW-1] ? AngW'(-angle) : AngW'(angle);
	assign sum   = {1'b0, prod_hi_q, 16'b0} + {18'b0, prod_lo_q} + 64'h2000_0000;
	assign t_mag = sum[61:30];
	assign t     = neg_q ? (32'd0 - t_mag) : t_mag;
	assign tq    = t + 32'h2000_0000;
	assign quad  = tq[31:30];
	assign resid = t - {quad, 30'b0};

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = atan_turn(step_q[4:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			conv_q <= 1'b1;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (conv_q) begin
			conv_q <= 1'b0;
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + StepW'(1);
			if (step_q == StepW'(CORDIC_STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_hi_q <= {30'b0, mag[32:16]} * {17'b0, TurnScale};
			prod_lo_q <= {30'b0, mag[15:0]} * {16'b0, TurnScale};
			neg_q     <= angle[AngW-1];
		end else if (conv_q) begin
			quad_q <= quad;
			x_q    <= CordicGain;
			y_q    <= '0;
			z_q    <= {resid[31], resid};
		end else if (run_q) begin
			if (!z_q[AngW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// rotate by the quadrant removed before the iterations
	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

@@ design/nnhs_hav.sv @@
// Four-stage pipeline for the haversine term a in Q1.31.
// Depends on nnhs_pkg.
module nnhs_hav import nnhs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [TrigW-1:0] c1,
	input  logic signed [TrigW-1:0] c2,
	input  logic signed [TrigW-1:0] sh,
	input  logic signed [TrigW-1:0] sl,
	output logic                    valid,
	output logic [AW-1:0]           a
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [65:0] m1_s1, m2_s1, m3_s1;
	logic signed [33:0] p_s2, q2_s2;
	logic signed [65:0] m3_s2, m3_s3;
	logic signed [67:0] m4_s3;
	logic signed [67:0] acc;
	logic signed [67:0] rnd;
	logic signed [65:0] p_full;
	logic signed [65:0] q2_full;
	logic [AW-1:0]      a_s4;

	assign p_full  = (m1_s1 + 66'sd536870912) >>> 30;
	assign q2_full = (m2_s1 + 66'sd536870912) >>> 30;
	assign acc     = m4_s3 + 68'(m3_s3);
	assign rnd     = (acc + 68'sd268435456) >>> 29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1 <= 66'(c1) * 66'(c2);
		m2_s1 <= 66'(sl) * 66'(sl);
		m3_s1 <= 66'(sh) * 66'(sh);
		p_s2  <= 34'(p_full);
		q2_s2 <= 34'(q2_full);
		m3_s2 <= m3_s1;
		m4_s3 <= 68'(p_s2) * 68'(q2_s2);
		m3_s3 <= m3_s2;
		if (acc < 0) begin
			a_s4 <= '0;
		end else if (rnd > 68'sd2147483648) begin
			a_s4 <= 32'h8000_0000;
		end else begin
			a_s4 <= rnd[AW-1:0];
		end
	end

	assign valid = v_s4;
	assign a     = a_s4;

endmodule

@@ design/nnhs_datapath.sv @@
// Datapath: node tables, scan index, CORDIC units, haversine pipeline,
// best tracking and result registers. Depends on nnhs_pkg, nnhs_cordic, nnhs_hav.
module nnhs_datapath import nnhs_pkg::*; #(
	parameter int unsigned MAX_NODES    = MaxNodesDef,
	parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic signed [LatW-1:0] lat,
	input  logic signed [LonW-1:0] lon,
	output logic [IdxOutW-1:0]     node_index,
	output logic [StatW-1:0]       status,
	output logic                   was_new
);

	localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	logic [CoordW-1:0] lat_mem [MAX_NODES];
	logic [CoordW-1:0] lon_mem [MAX_NODES];

	logic signed [CoordW-1:0] q_lat_q, q_lon_q;
	logic signed [CoordW-1:0] rd_lat_q, rd_lon_q;
	logic [CW-1:0]            count_q;
	logic [IW-1:0]            idx_q;
	logic [IW-1:0]            rd_addr;
	logic [AW-1:0]            best_a_q;
	logic [IW-1:0]            best_idx_q;
	logic [IW-1:0]            best_next;
	logic                     win;
	logic [IW-1:0]            res_idx_q;
	status_t                  res_st_q;
	logic                     res_new_q;
	logic [IdxOutW-1:0]       out_idx_q;
	status_t                  out_st_q;
	logic                     out_new_q;

	logic signed [AngW-1:0]  ang_c1, ang_c2, ang_sh, ang_sl;
	logic signed [TrigW-1:0] c1, c2, sh, sl;
	logic signed [TrigW-1:0] s1_unused, s2_unused, ch_unused, cl_unused;
	logic [3:0]              cdone;
	logic                    a_valid;
	logic [AW-1:0]           a;

	always_comb begin
		if (cmd.idx_clr) begin
			rd_addr = '0;
		end else if (cmd.idx_inc) begin
			rd_addr = idx_q + IW'(1);
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			lat_mem[count_q[IW-1:0]] <= q_lat_q;
			lon_mem[count_q[IW-1:0]] <= q_lon_q;
		end
		if (cmd.rd_en) begin
			rd_lat_q <= lat_mem[rd_addr];
			rd_lon_q <= lon_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			q_lat_q <= CoordW'(lat);
			q_lon_q <= lon;
		end
	end

	assign ang_c1 = {q_lat_q, 1'b0};
	assign ang_c2 = {rd_lat_q, 1'b0};
	assign ang_sh = AngW'(rd_lat_q) - AngW'(q_lat_q);
	assign ang_sl = AngW'(rd_lon_q) - AngW'(q_lon_q);

	nnhs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_c1 (
		.clk, .arst_n, .start(cmd.cordic_start), .angle(ang_c1),
		.done(cdone[0]), .cos_val(c1), .sin_val(s1_unused)
	);
	nnhs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_c2 (
		.clk, .arst_n, .start(cmd.cordic_start), .angle(ang_c2),
		.done(cdone[1]), .cos_val(c2), .sin_val(s2_unused)
	);
	nnhs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_sh (
		.clk, .arst_n, .start(cmd.cordic_start), .angle(ang_sh),
		.done(cdone[2]), .cos_val(ch_unused), .sin_val(sh)
	);
	nnhs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_sl (
		.clk, .arst_n, .start(cmd.cordic_start), .angle(ang_sl),
		.done(cdone[3]), .cos_val(cl_unused), .sin_val(sl)
	);

	nnhs_hav u_hav (
		.clk, .arst_n, .start(cmd.hav_start),
		.c1, .c2, .sh, .sl, .valid(a_valid), .a
	);

	// first node always takes the lead; later ones only on a strictly smaller a
	assign win       = (idx_q == '0) || (a < best_a_q);
	assign best_next = win ? idx_q : best_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.best_upd && win) begin
			best_a_q   <= a;
			best_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_found) begin
			res_idx_q <= idx_q;
			res_st_q  <= ST_OK;
			res_new_q <= 1'b0;
		end else if (cmd.res_new) begin
			res_idx_q <= count_q[IW-1:0];
			res_st_q  <= ST_OK;
			res_new_q <= 1'b1;
		end else if (cmd.res_full) begin
			res_idx_q <= '0;
			res_st_q  <= ST_FULL;
			res_new_q <= 1'b0;
		end else if (cmd.res_empty) begin
			res_idx_q <= '0;
			res_st_q  <= ST_EMPTY;
			res_new_q <= 1'b0;
		end else if (cmd.res_best) begin
			res_idx_q <= best_next;
			res_st_q  <= ST_OK;
			res_new_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_idx_q <= IdxOutW'(res_idx_q);
			out_st_q  <= res_st_q;
			out_new_q <= res_new_q;
		end
	end

	assign sts.cnt_zero    = (count_q == '0);
	assign sts.cnt_full    = (count_q == CW'(MAX_NODES));
	assign sts.idx_last    = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.match       = (rd_lat_q == q_lat_q) && (rd_lon_q == q_lon_q);
	assign sts.cordic_done = &cdone;
	assign sts.a_valid     = a_valid;

	assign node_index = out_idx_q;
	assign status     = out_st_q;
	assign was_new    = out_new_q;

endmodule

@@ design/nnhs_ctrl.sv @@
// Controller state machine: sequences the add lookup, the nearest-node scan
// and the output handoff. Depends on nnhs_pkg.
module nnhs_ctrl import nnhs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_func,
	output logic item_ready,
	output logic result_valid,
	input  logic result_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					cmd.idx_clr   = 1'b1;
					if (item_func == FUNC_ADD) begin
						if (sts.cnt_zero) begin
							state_d = S_ADD_END;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_ADD_CMP;
						end
					end else begin
						if (sts.cnt_zero) begin
							cmd.res_empty = 1'b1;
							state_d       = S_FIN;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_Q_START;
						end
					end
				end
			end
			S_ADD_CMP: begin
				if (sts.match) begin
					cmd.res_found = 1'b1;
					state_d       = S_FIN;
				end else if (sts.idx_last) begin
					state_d = S_ADD_END;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.rd_en   = 1'b1;
				end
			end
			S_ADD_END: begin
				if (sts.cnt_full) begin
					cmd.res_full = 1'b1;
				end else begin
					cmd.append  = 1'b1;
					cmd.res_new = 1'b1;
				end
				state_d = S_FIN;
			end
			S_Q_START: begin
				cmd.cordic_start = 1'b1;
				state_d          = S_Q_WAIT;
			end
			S_Q_WAIT: begin
				if (sts.cordic_done) begin
					cmd.hav_start = 1'b1;
					state_d       = S_Q_HAV;
				end
			end
			S_Q_HAV: begin
				if (sts.a_valid) begin
					cmd.best_upd = 1'b1;
					if (sts.idx_last) begin
						cmd.res_best = 1'b1;
						state_d      = S_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						cmd.rd_en   = 1'b1;
						state_d     = S_Q_START;
					end
				end
			end
			S_FIN: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

@@ design/nearest_node_haversine_search.sv @@
// Add item: one stored node is compared per cycle. Query item: each node runs
// the four shared iterative CORDIC units, one rotation per cycle, then the
// four-stage haversine pipeline. One item is in work at a time; the output
// register lets the next item enter while a result waits. arst_n clears the
// node count and control; the node tables hold no reset value.
`include "assert_macros.svh"

module nearest_node_haversine_search import nnhs_pkg::*; #(
	parameter int unsigned MAX_NODES    = MaxNodesDef,
	parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	nnhs_item_if.sink     item,
	nnhs_result_if.source result
);

	cmd_t cmd;
	sts_t sts;

	// controller: walks the table for an add, drives the per-node
	// CORDIC/haversine sequence for a query, and hands off the result
	nnhs_ctrl u_ctrl (
		.clk,
		.arst_n,
		.item_valid  (item.valid),
		.item_func   (item.func),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.sts,
		.cmd
	);

	// datapath: node tables, arithmetic units and result registers
	nnhs_datapath #(
		.MAX_NODES   (MAX_NODES),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk,
		.arst_n,
		.cmd,
		.sts,
		.lat       (item.lat),
		.lon       (item.lon),
		.node_index(result.node_index),
		.status    (result.status),
		.was_new   (result.was_new)
	);

	// node count can never read as both empty and full
	`NNHS_ASSERT(a_count_sane, !(sts.cnt_zero && sts.cnt_full))
	// an accepted transaction blocks the input until its work is done
	`NNHS_NEXT(a_one_item, item.valid && item.ready, !item.ready)
	// an appended node is always reported with ok status
	`NNHS_IMPLY(a_new_ok, result.valid && result.was_new, result.status == ST_OK)
	// CORDIC starts only inside a query scan
	`NNHS_IMPLY(a_start_busy, cmd.cordic_start, !item.ready)

endmodule

@@ bench/nearest_node_haversine_search_test.sv @@
// Testbench of nearest_node_haversine_search: directed and random add/query
// transactions checked against a bit-accurate haversine search predictor.
// Depends on nnhs_pkg, nnhs_item_if, nnhs_result_if and the block itself.
`timescale 1ns / 1ps

module nearest_node_haversine_search_test;
	import nnhs_pkg::*;

	localparam int unsigned TableSize   = 1024;
	localparam int unsigned RotSteps    = 24;
	// Allow several times the longest legal query over a full table.
	localparam int unsigned IdleLimit   = 200000;
	localparam int unsigned RandomItems = 540;
	localparam int unsigned SparseNodes = 30;

	typedef struct {
		logic [IdxOutW-1:0] node_index;
		status_t            status;
		logic               was_new;
	} search_result_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam longint AtanTurns [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	// Mirror of the node table plus the queue of results still owed.
	class node_search_board;
		longint         lat_tab [TableSize];
		longint         lon_tab [TableSize];
		int unsigned    count;
		search_result_t owed [$];
		int unsigned    errors;

		function longint to_turn(longint x);
			bit [63:0] mag;
			bit [63:0] prod;
			bit [31:0] t;
			mag  = (x < 0) ? -x : x;
			prod = mag * 64'd640511947 + 64'd536870912;
			t    = prod[61:30];
			if (x < 0)
				t = -t;
			return longint'(t);
		endfunction

		function void rotate(longint turn, output longint c, output longint s);
			bit [31:0] t;
			bit [31:0] q;
			bit [31:0] d;
			longint    x;
			longint    y;
			longint    z;
			longint    dx;
			longint    dy;
			t = turn[31:0];
			q = ((t + 32'h2000_0000) >> 30) & 32'd3;
			d = t - (q << 30);
			z = longint'(signed'(d));
			x = 652032874;
			y = 0;
			for (int i = 0; i < RotSteps; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= AtanTurns[i];
				end else begin
					x += dx; y -= dy; z += AtanTurns[i];
				end
			end
			case (q)
				0: begin c = x;  s = y;  end
				1: begin c = -y; s = x;  end
				2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		// Haversine term a in Q1.31 between query point 1 and stored point 2.
		function longint hav_term(longint la1, longint lo1, longint la2, longint lo2);
			longint c1, s1, c2, s2, ch, sh, cl, sl, p, q2, acc;
			rotate(to_turn(2 * la1), c1, s1);
			rotate(to_turn(2 * la2), c2, s2);
			rotate(to_turn(la2 - la1), ch, sh);
			rotate(to_turn(lo2 - lo1), cl, sl);
			p   = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
			q2  = (sl * sl + (64'sd1 <<< 29)) >>> 30;
			acc = sh * sh + p * q2;
			if (acc < 0)
				return 0;
			acc = (acc + (64'sd1 <<< 28)) >>> 29;
			if (acc > 64'sd2147483648)
				return 64'sd2147483648;
			return acc;
		endfunction

		// Note an accepted transaction: update the table and owe one result.
		function void note_item(logic func, longint lat, longint lon);
			search_result_t r;
			longint best;
			longint a;
			bit found;
			r = '{node_index: '0, status: ST_OK, was_new: 1'b0};
			if (func == FUNC_ADD) begin
				found = 0;
				for (int i = 0; i < count && !found; i++)
					if (lat_tab[i] == lat && lon_tab[i] == lon) begin
						r.node_index = i[IdxOutW-1:0];
						found = 1;
					end
				if (!found) begin
					if (count < TableSize) begin
						r.node_index = count[IdxOutW-1:0];
						lat_tab[count] = lat;
						lon_tab[count] = lon;
						count++;
						r.was_new = 1'b1;
					end else
						r.status = ST_FULL;
				end
			end else if (count == 0)
				r.status = ST_EMPTY;
			else begin
				best = hav_term(lat, lon, lat_tab[0], lon_tab[0]);
				for (int i = 1; i < count; i++) begin
					a = hav_term(lat, lon, lat_tab[i], lon_tab[i]);
					if (a < best) begin
						best = a;
						r.node_index = i[IdxOutW-1:0];
					end
				end
			end
			owed = {owed, r};
		endfunction

		function void check_result(logic [IdxOutW-1:0] idx, logic [StatW-1:0] st,
				logic nw);
			search_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result index=%0d status=%0d was_new=%0d",
					$time, idx, st, nw);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (idx !== e.node_index) begin
				$display("%0t: node_index expected %0d actual %0d", $time,
					e.node_index, idx);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (nw !== e.was_new) begin
				$display("%0t: was_new expected %0d actual %0d", $time, e.was_new, nw);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;   // when set, neither side idles
	int unsigned idle_cycles;

	nnhs_item_if   item ();
	nnhs_result_if result ();

	nearest_node_haversine_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	node_search_board board = new();

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, sometimes a few cycles, rarely a long one; none while steady is set.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one transaction and hold it until the block takes it.
	task automatic send_item(logic func, logic signed [LatW-1:0] lat,
			logic signed [LonW-1:0] lon);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.func  <= func;
		item.lat   <= lat;
		item.lon   <= lon;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		board.note_item(func, longint'(lat), longint'(lon));
	endtask

	// Hold off until every owed result has come back.
	task automatic drain();
		item.valid <= 1'b0;
		@(posedge clk);
		while (board.owed.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [LatW-1:0] pick_lat();
		case ($urandom_range(0, 3))
			0: return LatW'($urandom);
			1: return LatW'($urandom_range(0, 2000) - 1000);
			default: return LatW'(longint'($urandom_range(0, 1800000000)) - 900000000);
		endcase
	endfunction

	function automatic logic signed [LonW-1:0] pick_lon();
		case ($urandom_range(0, 3))
			0: return LonW'($urandom);
			1: return LonW'($urandom_range(0, 2000) - 1000);
			default: return LonW'(longint'($urandom_range(0, 3600000000)) - 1800000000);
		endcase
	endfunction

	// Sink side: accept in bursts, stall at random in between.
	initial begin
		int unsigned g;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				result.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && result.valid && result.ready)
			board.check_result(result.node_index, result.status, result.was_new);

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IdleLimit) begin
			$display("tb: failure");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		longint pl;
		longint po;
		int unsigned k;
		int unsigned r;
		item.valid = 1'b0;
		item.func  = FUNC_ADD;
		item.lat   = '0;
		item.lon   = '0;
		arst_n     = 1'b0;
		steady     = 1'b0;
		idle_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table query must come first since reset is not repeated.
		send_item(FUNC_QUERY, 31'sd0, 32'sd0);
		send_item(FUNC_ADD, 31'sd900000000, 32'sd1800000000);
		send_item(FUNC_ADD, -31'sd900000000, -32'sd1800000000);
		send_item(FUNC_ADD, 31'sd0, 32'sd0);
		send_item(FUNC_ADD, 31'sd900000000, 32'sd1800000000);   // already stored
		send_item(FUNC_ADD, 31'sd0, 32'sd100000000);             // tie pair around
		send_item(FUNC_ADD, 31'sd0, -32'sd100000000);            // longitude zero
		send_item(FUNC_QUERY, 31'sd0, 32'sd0);                   // exact hit
		send_item(FUNC_QUERY, 31'sd0, 32'sd1800000000);          // antipode of origin
		send_item(FUNC_QUERY, 31'sd1, -32'sd1);
		// Coordinates past the legal range wrap around the circle.
		send_item(FUNC_ADD, -31'sd1073741824, -32'sd2147483648);
		send_item(FUNC_ADD, 31'sd1073741823, 32'sd2147483647);
		send_item(FUNC_QUERY, 31'sd1073741823, 32'sd2147483647);
		send_item(FUNC_QUERY, -31'sd1073741824, -32'sd2147483648);
		send_item(FUNC_QUERY, 31'sd450000000, 32'sd0);
		drain();

		// Random: keep the table small so queries stay short.
		for (int n = 0; n < RandomItems; n++) begin
			if (n % 120 == 60)
				steady = ~steady;
			if (n == 300)
				drain();
			r = $urandom_range(0, 99);
			if (board.count < SparseNodes && r < 50)
				send_item(FUNC_ADD, pick_lat(), pick_lon());
			else if (r < 70) begin
				// Repeat a stored node so the lookup path hits.
				k  = $urandom_range(0, board.count - 1);
				send_item(FUNC_ADD, LatW'(board.lat_tab[k]), LonW'(board.lon_tab[k]));
			end else if (r < 85) begin
				k  = $urandom_range(0, board.count - 1);
				pl = board.lat_tab[k] + $urandom_range(0, 2000) - 1000;
				po = board.lon_tab[k] + $urandom_range(0, 2000) - 1000;
				send_item(FUNC_QUERY, LatW'(pl), LonW'(po));
			end else
				send_item(FUNC_QUERY, pick_lat(), pick_lon());
		end
		steady = 1'b0;
		drain();

		// Close with one more scan over the whole table.
		send_item(FUNC_QUERY, 31'sd12345, 32'sd67890);
		item.valid <= 1'b0;

		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
